/* hdl/life_generation_row_stencil_macros.svh */
// Assertion helpers shared by the Life stencil RTL.
// The clocked forms use clk, and the guarded forms use rst_n, of the module that uses them.
`ifndef LIFE_GENERATION_ROW_STENCIL_MACROS_SVH
`define LIFE_GENERATION_ROW_STENCIL_MACROS_SVH

`ifndef SYNTH

// Check a property while the block is out of reset.
`define LGRS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property at every edge, reset included.
`define LGRS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define LGRS_ASSERT(lbl, prop, msg)
`define LGRS_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

/* hdl/lgrs_pkg.sv */
package lgrs_pkg;

  // Row geometry
  localparam int ROW_W   = 64;
  localparam int COLUMNS = 64;
  localparam logic [ROW_W-1:0] ROW_MASK = {ROW_W{1'b1}} >> (ROW_W - COLUMNS);

  // B3/S23 rule counts
  localparam int CNT_W = 4;
  localparam logic [CNT_W-1:0] BIRTH_COUNT   = CNT_W'(3);
  localparam logic [CNT_W-1:0] SURVIVE_COUNT = CNT_W'(2);

  // Result queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [ROW_W-1:0] row_cells;
    logic             first_row;
    logic             last_row;
  } in_beat_t;

  typedef struct packed {
    logic [ROW_W-1:0] next_row_cells;
    logic             frame_end;
  } out_beat_t;

endpackage

/* hdl/lgrs_lane.sv */
module lgrs_lane (
  input  logic [2:0] above_win,
  input  logic [2:0] here_win,
  input  logic [2:0] below_win,
  output logic       next_cell
);
  import lgrs_pkg::*;

  logic [CNT_W-1:0] count;

  // Count the eight neighbors around the center cell
  assign count = CNT_W'(above_win[0]) + CNT_W'(above_win[1]) + CNT_W'(above_win[2]) +
                 CNT_W'(here_win[0])  + CNT_W'(here_win[2]) +
                 CNT_W'(below_win[0]) + CNT_W'(below_win[1]) + CNT_W'(below_win[2]);

  // Birth on three, survive on two
  assign next_cell = (count == BIRTH_COUNT) || (here_win[1] && (count == SURVIVE_COUNT));

endmodule

/* hdl/lgrs_row_gen.sv */
module lgrs_row_gen (
  input  logic [lgrs_pkg::ROW_W-1:0] above,
  input  logic [lgrs_pkg::ROW_W-1:0] here,
  input  logic [lgrs_pkg::ROW_W-1:0] below,
  output logic [lgrs_pkg::ROW_W-1:0] next_row
);
  import lgrs_pkg::*;

  logic [ROW_W+1:0] above_pad;
  logic [ROW_W+1:0] here_pad;
  logic [ROW_W+1:0] below_pad;
  logic [ROW_W-1:0] lane_out;

  // Pad both edges with dead cells; drop columns past the grid
  assign above_pad = {1'b0, above & ROW_MASK, 1'b0};
  assign here_pad  = {1'b0, here & ROW_MASK, 1'b0};
  assign below_pad = {1'b0, below & ROW_MASK, 1'b0};

  // One lane per column
  for (genvar c = 0; c < ROW_W; c++) begin : g_col
    if (c < COLUMNS) begin : g_lane
      lgrs_lane u_lane (
        .above_win (above_pad[c+2:c]),
        .here_win  (here_pad[c+2:c]),
        .below_win (below_pad[c+2:c]),
        .next_cell (lane_out[c])
      );
    end else begin : g_off
      assign lane_out[c] = 1'b0;
    end
  end

  // Merge the lane bits into the result row
  assign next_row = lane_out & ROW_MASK;

endmodule

/* hdl/life_generation_row_stencil.sv */
// Streams one B3/S23 Life generation: each in_ beat is one grid row (bit c is column c), rows
// of a frame arrive top to bottom, and 64 column lanes compute a whole row in the cycle the
// beat is accepted, so one row is taken every cycle while the four-entry result queue has
// room for two beats. A row emits the next generation of the row above it (none for the top
// row), and the bottom row also emits its own next generation, with frame_end set. Cells
// outside the grid count as dead, and the first result of a row leaves on out_ in the cycle
// after its input is accepted at the earliest.
module life_generation_row_stencil (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  lgrs_pkg::in_beat_t  in_beat,
  output logic                out_valid,
  input  logic                out_stall,
  output lgrs_pkg::out_beat_t out_beat
);
  import lgrs_pkg::*;

  `include "life_generation_row_stencil_macros.svh"

  // Line buffer
  logic [ROW_W-1:0] upper_r, upper_nxt;
  logic [ROW_W-1:0] middle_r, middle_nxt;
  logic             mid_valid_r, mid_valid_nxt;

  // Result queue
  out_beat_t          fifo_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CW-1:0] count_r, count_nxt;

  logic             in_acc;
  logic             out_acc;
  logic [ROW_W-1:0] row_in;
  logic             restart;
  logic             push_a;
  logic             push_b;
  logic [FIFO_AW-1:0] wr_b_idx;
  logic [ROW_W-1:0] gen_a_row;
  logic [ROW_W-1:0] gen_b_row;
  logic [ROW_W-1:0] gen_b_above;
  out_beat_t        res_a;
  out_beat_t        res_b;
  logic             top_only;
  logic [FIFO_AW-1:0] ptr_gap;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign row_in  = in_beat.row_cells & ROW_MASK;
  assign restart = in_beat.first_row || !mid_valid_r;

  // Hold input while fewer than two slots are free
  assign in_stall = (count_r > FIFO_CW'(FIFO_DEPTH - 2));

  // Middle row with the new row below it
  lgrs_row_gen u_gen_a (
    .above    (upper_r),
    .here     (middle_r),
    .below    (row_in),
    .next_row (gen_a_row)
  );

  // Bottom row with a dead row below it
  assign gen_b_above = restart ? '0 : middle_r;

  lgrs_row_gen u_gen_b (
    .above    (gen_b_above),
    .here     (row_in),
    .below    ('0),
    .next_row (gen_b_row)
  );

  assign res_a = '{next_row_cells: gen_a_row, frame_end: 1'b0};
  assign res_b = '{next_row_cells: gen_b_row, frame_end: 1'b1};

  assign push_a   = in_acc && !restart;
  assign push_b   = in_acc && in_beat.last_row;
  assign wr_b_idx = wr_ptr_r + FIFO_AW'(push_a);

  // Advance the line buffer
  always_comb begin
    upper_nxt     = upper_r;
    middle_nxt    = middle_r;
    mid_valid_nxt = mid_valid_r;
    if (in_acc) begin
      if (in_beat.last_row) begin
        upper_nxt     = '0;
        middle_nxt    = '0;
        mid_valid_nxt = 1'b0;
      end else if (restart) begin
        upper_nxt     = '0;
        middle_nxt    = row_in;
        mid_valid_nxt = 1'b1;
      end else begin
        upper_nxt  = middle_r;
        middle_nxt = row_in;
      end
    end
  end

  // Advance queue pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + FIFO_AW'(push_a) + FIFO_AW'(push_b);
    rd_ptr_nxt = rd_ptr_r + FIFO_AW'(out_acc);
    count_nxt  = count_r + FIFO_CW'(push_a) + FIFO_CW'(push_b) - FIFO_CW'(out_acc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upper_r     <= '0;
      middle_r    <= '0;
      mid_valid_r <= 1'b0;
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      count_r     <= '0;
    end else begin
      upper_r     <= upper_nxt;
      middle_r    <= middle_nxt;
      mid_valid_r <= mid_valid_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      count_r     <= count_nxt;
    end
  end

  // Write result beats in stream order
  always_ff @(posedge clk) begin
    if (push_a) begin
      fifo_r[wr_ptr_r] <= res_a;
    end
    if (push_b) begin
      fifo_r[wr_b_idx] <= res_b;
    end
  end

  // Present the queue head
  assign out_valid = (count_r != '0);
  assign out_beat  = fifo_r[rd_ptr_r];

  // Top row that opens a frame without closing it
  assign top_only = in_acc && restart && !in_beat.last_row;
  assign ptr_gap  = wr_ptr_r - rd_ptr_r;

  `LGRS_ASSERT(a_fifo_bound, count_r <= FIFO_CW'(FIFO_DEPTH), "result queue overfilled")
  `LGRS_ASSERT(a_idle_buffer_clear, !mid_valid_r |-> (upper_r | middle_r) == '0, "stale rows")
  `LGRS_ASSERT(a_last_closes, (in_acc && in_beat.last_row) |=> !mid_valid_r, "frame left open")
  `LGRS_ASSERT(a_top_silent, top_only |=> count_r <= $past(count_r), "top row emitted")
  `LGRS_ASSERT(a_ptr_gap, count_r[FIFO_AW-1:0] == ptr_gap, "pointers disagree")

endmodule

/* dv/testbench.sv */
module testbench;
  import lgrs_pkg::*;

  localparam int TOTAL_ROWS  = 1800;
  localparam int LONG_AT     = 700;   // rows accepted before the long output hold
  localparam int LONG_HOLD   = 120;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 8;

  typedef struct {
    in_beat_t    beat;
    int unsigned gap;
    bit          drain;
  } row_item_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_beat_t  in_beat = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_beat;

  row_item_t   row_q[$];
  out_beat_t   next_gen_q[$];
  int unsigned rows_accepted = 0;
  int unsigned total_rows;
  int unsigned errors = 0;
  int unsigned idle_cycles = 0;

  // Line buffer of the predictor
  logic [ROW_W-1:0] upper_row = '0;
  logic [ROW_W-1:0] middle_row = '0;
  bit               middle_live = 1'b0;

  life_generation_row_stencil dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_beat  (in_beat),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_beat (out_beat)
  );

  always #5 clk = ~clk;

  // B3/S23 rule on one row, cells past the grid edges dead
  function automatic logic [ROW_W-1:0] life_step(input logic [ROW_W-1:0] above,
                                                 input logic [ROW_W-1:0] here,
                                                 input logic [ROW_W-1:0] below);
    logic [ROW_W-1:0] nxt;
    int unsigned      cnt;
    nxt = '0;
    for (int c = 0; c < COLUMNS; c++) begin
      cnt = 0;
      for (int d = -1; d <= 1; d++) begin
        if (c + d >= 0 && c + d < COLUMNS) begin
          cnt += above[c+d] + below[c+d];
          if (d != 0) cnt += here[c+d];
        end
      end
      if (cnt == BIRTH_COUNT || (here[c] && cnt == SURVIVE_COUNT)) nxt[c] = 1'b1;
    end
    return nxt & ROW_MASK;
  endfunction

  // Advance the line buffer by one row and queue the rows it completes
  task automatic predict_rows(input in_beat_t b);
    logic [ROW_W-1:0] row;
    out_beat_t        res;
    row = b.row_cells & ROW_MASK;
    if (b.first_row || !middle_live) begin
      upper_row   = '0;
      middle_row  = row;
      middle_live = 1'b1;
    end else begin
      res.next_row_cells = life_step(upper_row, middle_row, row);
      res.frame_end      = 1'b0;
      next_gen_q.push_back(res);
      upper_row  = middle_row;
      middle_row = row;
    end
    if (b.last_row) begin
      res.next_row_cells = life_step(upper_row, middle_row, '0);
      res.frame_end      = 1'b1;
      next_gen_q.push_back(res);
      upper_row   = '0;
      middle_row  = '0;
      middle_live = 1'b0;
    end
  endtask

  // Queue one row; gaps vanish in calm stretches and around the long output hold
  task automatic add_row(input logic [ROW_W-1:0] cells, input logic top, input logic bottom,
                         input bit drain);
    row_item_t   it;
    int unsigned idx;
    idx = row_q.size();
    it.beat.row_cells = cells;
    it.beat.first_row = top;
    it.beat.last_row  = bottom;
    it.drain          = drain;
    if ((idx >= LONG_AT && idx < LONG_AT + 200) || (idx / 200) % 3 == 2)
      it.gap = 0;
    else
      it.gap = $urandom_range(0, 8);
    row_q.push_back(it);
  endtask

  // Mix sparse, dense and plain random rows
  function automatic logic [ROW_W-1:0] rand_row();
    logic [ROW_W-1:0] a;
    logic [ROW_W-1:0] b;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0: return a & b & {$urandom, $urandom};
      1: return a & b;
      2: return a | b;
      default: return a;
    endcase
  endfunction

  // Stimulus, reset and end of run
  initial begin
    int unsigned h;
    bit          noisy;
    bit          drain;
    // No open frame and no top mark, then a bottom row closing it
    add_row(rand_row(), 1'b0, 1'b0, 1'b0);
    add_row({ROW_W{1'b1}}, 1'b0, 1'b1, 1'b0);
    // One-row frames at both extremes
    add_row({ROW_W{1'b1}}, 1'b1, 1'b1, 1'b0);
    add_row('0, 1'b1, 1'b1, 1'b0);
    // Edge columns and full rows
    add_row(64'h8000_0000_0000_0001, 1'b1, 1'b0, 1'b0);
    add_row({ROW_W{1'b1}}, 1'b0, 1'b0, 1'b0);
    add_row('0, 1'b0, 1'b0, 1'b0);
    add_row({ROW_W{1'b1}}, 1'b0, 1'b1, 1'b0);
    // Blinker, cut off by a new top row inside the open frame
    add_row(64'h8, 1'b1, 1'b0, 1'b0);
    add_row(64'h8, 1'b0, 1'b0, 1'b0);
    add_row(64'h8, 1'b1, 1'b0, 1'b0);
    add_row(64'h8, 1'b0, 1'b0, 1'b0);
    add_row(64'h8, 1'b0, 1'b1, 1'b0);
    // Bottom mark with no open frame acts as a one-row frame
    add_row(64'h7, 1'b0, 1'b1, 1'b0);
    // Glider near the left edge and one near the right edge
    add_row(64'h2, 1'b1, 1'b0, 1'b0);
    add_row(64'h4, 1'b0, 1'b0, 1'b0);
    add_row(64'h7, 1'b0, 1'b0, 1'b0);
    add_row(64'hE000_0000_0000_0000, 1'b0, 1'b0, 1'b0);
    add_row(64'h4000_0000_0000_0000, 1'b0, 1'b0, 1'b0);
    add_row(64'h2000_0000_0000_0000, 1'b0, 1'b1, 1'b0);
    // Two-row frame
    add_row(64'hAAAA_5555_AAAA_5555, 1'b1, 1'b0, 1'b0);
    add_row(64'h5555_AAAA_5555_AAAA, 1'b0, 1'b1, 1'b0);

    // Random frames, mostly well formed
    drain = 1'b1;
    while (row_q.size() < TOTAL_ROWS) begin
      h     = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
      noisy = ($urandom_range(0, 6) == 0);
      for (int r = 0; r < h; r++) begin
        if (noisy)
          add_row(rand_row(), $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0, 1'b0);
        else
          add_row(rand_row(), r == 0, r == h - 1, drain && r == 0);
      end
      drain = ($urandom_range(0, 24) == 0);
    end
    total_rows = row_q.size();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (rows_accepted < total_rows || next_gen_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (next_gen_q.size() != 0) begin
      $display("%0t: missing beat, expected next_row_cells=%h frame_end=%b actual none",
               $time, next_gen_q[0].next_row_cells, next_gen_q[0].frame_end);
      errors++;
    end
    if (errors == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end

  // Row driver: hold a stalled beat, idle for the row's gap, pause to drain when asked
  int unsigned gap_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_rows(in_beat);
        rows_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (row_q.size() != 0 && !(row_q[0].drain && next_gen_q.size() != 0)) begin
          in_beat  <= row_q[0].beat;
          in_valid <= 1'b1;
          gap_left = row_q[0].gap;
          void'(row_q.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: check each beat, then stall for a random count of cycles
  int unsigned hold_left = 0;
  bit          long_done = 1'b0;
  out_beat_t   want;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (next_gen_q.size() == 0) begin
          $display("%0t: unexpected beat, expected none actual next_row_cells=%h frame_end=%b",
                   $time, out_beat.next_row_cells, out_beat.frame_end);
          errors++;
        end else begin
          want = next_gen_q.pop_front();
          if (want.next_row_cells !== out_beat.next_row_cells) begin
            $display("%0t: next_row_cells mismatch, expected %h actual %h",
                     $time, want.next_row_cells, out_beat.next_row_cells);
            errors++;
          end
          if (want.frame_end !== out_beat.frame_end) begin
            $display("%0t: frame_end mismatch, expected %b actual %b",
                     $time, want.frame_end, out_beat.frame_end);
            errors++;
          end
        end
        hold_left = ((rows_accepted / 250) % 3 == 1) ? 0 : $urandom_range(0, 8);
      end
      // Hold off long enough for the block to fill and stall its input
      if (!long_done && rows_accepted >= LONG_AT) begin
        long_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: end the run when no beat moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: timeout, no beat accepted for %0d cycles", $time, idle_cycles);
        $display("testbench failed");
        $finish;
      end
    end
  end

endmodule
